/* rtl/pwts_pkg.sv */
// Shared types and constants of the perspective world-to-screen core.
package pwts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int OFF_CAP_BITS  = 40;
    localparam int DIM_W         = 14;
    localparam int CFG_W         = 64;
    localparam int IDX_W         = 3;
    localparam int COEF_W        = 32;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X_01,
        REG_ROW_X_23,
        REG_ROW_Y_01,
        REG_ROW_Y_23,
        REG_ROW_W_01,
        REG_ROW_W_23,
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } point_t;

    typedef struct packed {
        logic               in_view;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } result_t;

    // Control that travels alongside each item through the divider
    typedef struct packed {
        logic valid;
        logic in_view;
        logic neg_x;
        logic neg_y;
    } ctl_t;

endpackage

/* rtl/pwts_div.sv */
// Pipelined restoring divider for the x and y viewport offsets, one bit per stage.
module pwts_div #(
    parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF,
    localparam int SW  = 66 - FRAC_BITS,
    localparam int CAP = pwts_pkg::OFF_CAP_BITS,
    localparam int NW  = SW + pwts_pkg::DIM_W + FRAC_BITS,
    localparam int DW  = SW + 1,
    localparam int HW  = NW - CAP,
    localparam int OW  = CAP + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pwts_pkg::ctl_t       ctl_in,
    input  logic [NW-1:0]        num_x,
    input  logic [NW-1:0]        num_y,
    input  logic [DW-1:0]        den,
    output pwts_pkg::ctl_t       ctl_out,
    output logic signed [OW-1:0] off_x,
    output logic signed [OW-1:0] off_y
);

    pwts_pkg::ctl_t   ctl_reg  [0:CAP];
    logic [DW-1:0]    den_reg  [0:CAP];
    logic [DW-1:0]    rem_x_reg[0:CAP];
    logic [DW-1:0]    rem_y_reg[0:CAP];
    logic [CAP-1:0]   ql_x_reg [0:CAP];
    logic [CAP-1:0]   ql_y_reg [0:CAP];
    logic             over_x_reg[0:CAP];
    logic             over_y_reg[0:CAP];

    logic [DW-1:0]    hi_x;
    logic [DW-1:0]    hi_y;
    logic [CAP:0]     mag_x;
    logic [CAP:0]     mag_y;

    assign hi_x = DW'(num_x[NW-1:CAP]);
    assign hi_y = DW'(num_y[NW-1:CAP]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CAP; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 1; k <= CAP; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Entry stage: quotient reaching the cap is flagged, the rest starts the long division
    always_ff @(posedge clk)
    begin
        den_reg[0]    <= den;
        over_x_reg[0] <= hi_x >= den;
        over_y_reg[0] <= hi_y >= den;
        rem_x_reg[0]  <= hi_x;
        rem_y_reg[0]  <= hi_y;
        ql_x_reg[0]   <= num_x[CAP-1:0];
        ql_y_reg[0]   <= num_y[CAP-1:0];
    end

    for (genvar k = 1; k <= CAP; k++)
    begin : g_bit
        logic [DW:0] tx;
        logic [DW:0] ty;
        logic        gex;
        logic        gey;

        assign tx  = {rem_x_reg[k-1], ql_x_reg[k-1][CAP-1]};
        assign ty  = {rem_y_reg[k-1], ql_y_reg[k-1][CAP-1]};
        assign gex = tx >= {1'b0, den_reg[k-1]};
        assign gey = ty >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            den_reg[k]    <= den_reg[k-1];
            over_x_reg[k] <= over_x_reg[k-1];
            over_y_reg[k] <= over_y_reg[k-1];
            rem_x_reg[k]  <= gex ? DW'(tx - {1'b0, den_reg[k-1]}) : tx[DW-1:0];
            rem_y_reg[k]  <= gey ? DW'(ty - {1'b0, den_reg[k-1]}) : ty[DW-1:0];
            ql_x_reg[k]   <= {ql_x_reg[k-1][CAP-2:0], gex};
            ql_y_reg[k]   <= {ql_y_reg[k-1][CAP-2:0], gey};
        end
    end

    assign mag_x = over_x_reg[CAP] ? {1'b1, {CAP{1'b0}}} : {1'b0, ql_x_reg[CAP]};
    assign mag_y = over_y_reg[CAP] ? {1'b1, {CAP{1'b0}}} : {1'b0, ql_y_reg[CAP]};

    assign off_x = ctl_reg[CAP].neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    assign off_y = ctl_reg[CAP].neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    assign ctl_out = ctl_reg[CAP];

endmodule

/* rtl/perspective_world_to_screen_core.sv */
// Top level of the perspective world-to-screen projection core.
//
// Usage:
//   Raise start with a world point on point; the item is taken at every
//   clock edge where start is high and busy is low. busy is high only while
//   reset is applied, so one point may enter in every cycle.
//   Each result appears on result for exactly one cycle, marked by
//   result_valid. The receiver cannot stall the core; results must be
//   taken when shown. Throughput is one item per cycle; the pipeline holds
//   the 40 stages of the offset divider (one quotient bit each) plus the
//   multiply, sum, scale, divider entry and output stages.
//   The matrix rows and viewport size are written through wr_en, wr_index,
//   wr_data, one register per edge; the user must write them only while no
//   item is in flight, which the core does not enforce. Reset empties the
//   pipeline, clears the matrix and sets the viewport to 1920 by 1080.
module perspective_world_to_screen_core #(
    parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pwts_pkg::point_t              point,
    output logic                          result_valid,
    output pwts_pkg::result_t             result,
    input  logic                          wr_en,
    input  logic [pwts_pkg::IDX_W-1:0]    wr_index,
    input  logic [pwts_pkg::CFG_W-1:0]    wr_data
);

    localparam int SW   = 66 - FRAC_BITS;
    localparam int CAP  = pwts_pkg::OFF_CAP_BITS;
    localparam int DIMW = pwts_pkg::DIM_W;
    localparam int NW   = SW + DIMW + FRAC_BITS;
    localparam int DW   = SW + 1;
    localparam int OW   = CAP + 2;
    localparam int SUMW = OW + 1;
    localparam int LAT  = CAP + 5;
    localparam logic signed [SW-1:0] NEAR_W = SW'(((1 << FRAC_BITS) + 500) / 1000);

    // Configuration registers
    logic [pwts_pkg::CFG_W-1:0] coef_reg [0:5];
    logic [DIMW-1:0]            width_reg;
    logic [DIMW-1:0]            height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                coef_reg[i] <= '0;
            end
            width_reg  <= pwts_pkg::WIDTH_RESET;
            height_reg <= pwts_pkg::HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (pwts_pkg::reg_index_t'(wr_index))
                pwts_pkg::REG_ROW_X_01:      coef_reg[0] <= wr_data;
                pwts_pkg::REG_ROW_X_23:      coef_reg[1] <= wr_data;
                pwts_pkg::REG_ROW_Y_01:      coef_reg[2] <= wr_data;
                pwts_pkg::REG_ROW_Y_23:      coef_reg[3] <= wr_data;
                pwts_pkg::REG_ROW_W_01:      coef_reg[4] <= wr_data;
                pwts_pkg::REG_ROW_W_23:      coef_reg[5] <= wr_data;
                pwts_pkg::REG_SCREEN_WIDTH:  width_reg   <= wr_data[DIMW-1:0];
                pwts_pkg::REG_SCREEN_HEIGHT: height_reg  <= wr_data[DIMW-1:0];
                default:                     width_reg   <= width_reg;
            endcase
        end
    end

    assign busy = ~rst_n;

    // Coefficient view: row 0 = x, row 1 = y, row 2 = w; four coefficients each
    logic signed [31:0] coef_s [0:2][0:3];
    logic signed [31:0] coord_s[0:2];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            coef_s[r][0] = coef_reg[2*r][31:0];
            coef_s[r][1] = coef_reg[2*r][63:32];
            coef_s[r][2] = coef_reg[2*r+1][31:0];
            coef_s[r][3] = coef_reg[2*r+1][63:32];
        end
        coord_s[0] = point.world_x;
        coord_s[1] = point.world_y;
        coord_s[2] = point.world_z;
    end

    // Stage 1: nine exact products
    logic               v1_reg;
    logic signed [63:0] prod_reg[0:2][0:2];

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[r][k] <= coef_s[r][k] * coord_s[k];
            end
        end
    end

    // Stage 2: floor-shift each product and sum the row with coefficient 3
    logic              v2_reg;
    logic              view2_reg;
    logic [SW-1:0]     sum_next[0:2];
    logic signed [SW-1:0] sum_reg[0:2];
    logic signed [63:0]   sh[0:2][0:2];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = {{(SW-32){coef_s[r][3][31]}}, coef_s[r][3]};
            for (int k = 0; k < 3; k++)
            begin
                sh[r][k]    = prod_reg[r][k] >>> FRAC_BITS;
                sum_next[r] = sum_next[r] + sh[r][k][SW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_reg[r] <= sum_next[r];
        end
        view2_reg <= $signed(sum_next[2]) >= NEAR_W;
    end

    // Stage 3: scale the clip magnitudes by the viewport size, form 2w
    pwts_pkg::ctl_t  ctl3_reg;
    logic [NW-1:0]   num_x_reg;
    logic [NW-1:0]   num_y_reg;
    logic [DW-1:0]   den_reg;
    logic [SW-1:0]   mag_x;
    logic [SW-1:0]   mag_y;
    logic [SW+DIMW-1:0] scl_x;
    logic [SW+DIMW-1:0] scl_y;

    assign mag_x = sum_reg[0][SW-1] ? SW'(-sum_reg[0]) : sum_reg[0];
    assign mag_y = sum_reg[1][SW-1] ? SW'(-sum_reg[1]) : sum_reg[1];
    assign scl_x = mag_x * width_reg;
    assign scl_y = mag_y * height_reg;

    always_ff @(posedge clk)
    begin
        num_x_reg <= {scl_x, {FRAC_BITS{1'b0}}};
        num_y_reg <= {scl_y, {FRAC_BITS{1'b0}}};
        den_reg   <= {sum_reg[2], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
        end
        else
        begin
            v1_reg         <= start & ~busy;
            v2_reg         <= v1_reg;
            ctl3_reg.valid   <= v2_reg;
            ctl3_reg.in_view <= view2_reg;
            ctl3_reg.neg_x   <= sum_reg[0][SW-1];
            ctl3_reg.neg_y   <= sum_reg[1][SW-1];
        end
    end

    // Divider stages
    pwts_pkg::ctl_t       ctl_d;
    logic signed [OW-1:0] off_x;
    logic signed [OW-1:0] off_y;

    pwts_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl3_reg),
        .num_x   (num_x_reg),
        .num_y   (num_y_reg),
        .den     (den_reg),
        .ctl_out (ctl_d),
        .off_x   (off_x),
        .off_y   (off_y)
    );

    // Output stage: add the half-size centre and saturate; out-of-view results get zero coordinates
    function automatic logic [31:0] sat32(input logic [SUMW-1:0] v);
        logic same;
        same = (&v[SUMW-1:31]) | ~(|v[SUMW-1:31]);
        if (same)
            return v[31:0];
        return v[SUMW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    logic signed [SUMW-1:0] hx;
    logic signed [SUMW-1:0] hy;
    logic signed [SUMW-1:0] sx;
    logic signed [SUMW-1:0] sy;

    assign hx = $signed(SUMW'({width_reg[DIMW-1:1], {FRAC_BITS{1'b0}}}));
    assign hy = $signed(SUMW'({height_reg[DIMW-1:1], {FRAC_BITS{1'b0}}}));
    assign sx = hx + SUMW'(off_x);
    assign sy = hy - SUMW'(off_y);

    logic              result_valid_reg;
    pwts_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= ctl_d.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg.in_view  <= ctl_d.in_view;
        result_reg.screen_x <= ctl_d.in_view ? sat32(sx) : 32'h0;
        result_reg.screen_y <= ctl_d.in_view ? sat32(sy) : 32'h0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Every item taken comes out after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT result_valid)
        else $error("result missing after fixed latency");

    // No result without an item taken a fixed time before
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LAT))
        else $error("result without matching item");

    // A point behind the near plane reports zero coordinates
    a_out_of_view: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.in_view) |-> (result.screen_x == 0 && result.screen_y == 0))
        else $error("out-of-view result carries coordinates");

endmodule
